// File: src/mme_pkg.sv
// ----------------------------------------------------------------------------
// Michael MIC engine package
// Shared types, codes and block-function helpers for the Michael MIC engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mme_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  typedef logic [31:0] word_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic REG_KEY_LOW  = 1'b0;
  localparam logic REG_KEY_HIGH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h5a;
  localparam word_t PAD_WORD = {24'h000000, PAD_BYTE};

  localparam word_t MASK_EVEN = 32'h00FF00FF;
  localparam word_t MASK_ODD  = 32'hFF00FF00;

  localparam int ROT_FIRST  = 17;
  localparam int ROT_THIRD  = 3;
  localparam int ROT_FOURTH = 30;

  function automatic word_t rot_left17(word_t v);
    return (v << ROT_FIRST) | (v >> (32 - ROT_FIRST));
  endfunction

  function automatic word_t rot_left3(word_t v);
    return (v << ROT_THIRD) | (v >> (32 - ROT_THIRD));
  endfunction

  function automatic word_t rot_left30(word_t v);
    return (v << ROT_FOURTH) | (v >> (32 - ROT_FOURTH));
  endfunction

  function automatic word_t swap_pairs(word_t v);
    return ((v & MASK_EVEN) << 8) | ((v & MASK_ODD) >> 8);
  endfunction

endpackage

`default_nettype wire

// File: src/michael_mic_engine.sv
// ----------------------------------------------------------------------------
// Michael MIC engine
// Michael message integrity code over one frame, one block step per cycle.
// ----------------------------------------------------------------------------
// Sequence: each block function is four steps on the shared xor/rotate/add unit;
//   a start runs four block functions, a data word one and the last item two
//   or three, after which the result loads the output register.
// Throughput: one transaction at a time; in_stall is high until the item ends.
// Reset: clears keys, chaining halves, frame flag, sequencer and output valid.
`default_nettype none

module michael_mic_engine (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        command,
  input  wire logic [47:0] dest_addr,
  input  wire logic [47:0] src_addr,
  input  wire logic [7:0]  priority_req,
  input  wire logic [31:0] data_word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        last,
  input  wire logic [63:0] expected_mic,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      mic_left,
  output logic [31:0]      mic_right,
  output logic             mic_match
);

  mme_pkg::state_t state;
  mme_pkg::state_t state_next;

  mme_pkg::word_t key_low;
  mme_pkg::word_t key_high;
  mme_pkg::word_t left;
  mme_pkg::word_t right;
  mme_pkg::word_t left_next;
  mme_pkg::word_t right_next;
  mme_pkg::word_t mix;
  mme_pkg::word_t word_q [4];
  mme_pkg::word_t tail_word;
  logic [63:0]    expected;
  logic           in_frame;
  logic           emit;
  logic [1:0]     step;
  logic [1:0]     blk_left;
  logic           accept;
  logic           run_en;
  logic           load_out;
  logic           run_done;

  assign accept   = in_valid && !in_stall;
  assign run_done = (step == 2'd3) && (blk_left == 2'd0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mme_pkg::ST_IDLE: begin
        if (accept && (command == mme_pkg::CMD_START || in_frame)) begin
          state_next = mme_pkg::ST_RUN;
        end
      end
      mme_pkg::ST_RUN: begin
        if (run_done) begin
          state_next = emit ? mme_pkg::ST_EMIT : mme_pkg::ST_IDLE;
        end
      end
      mme_pkg::ST_EMIT: begin
        if (!out_valid || !out_stall) begin
          state_next = mme_pkg::ST_IDLE;
        end
      end
      default: state_next = mme_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall = (state != mme_pkg::ST_IDLE);
    run_en   = (state == mme_pkg::ST_RUN);
    load_out = (state == mme_pkg::ST_EMIT) && (!out_valid || !out_stall);
  end

  // shared block-function step
  always_comb begin
    unique case (step)
      2'd0: mix = mme_pkg::rot_left17(right) ^ word_q[0];
      2'd1: mix = mme_pkg::swap_pairs(right);
      2'd2: mix = mme_pkg::rot_left3(right);
      2'd3: mix = mme_pkg::rot_left30(right);
      default: mix = mme_pkg::rot_left30(right);
    endcase
    left_next  = left ^ mix;
    right_next = right + left_next;
  end

  // pad the final partial word
  always_comb begin
    unique case (valid_bytes)
      3'd0: tail_word = mme_pkg::PAD_WORD;
      3'd1: tail_word = {16'h0000, mme_pkg::PAD_BYTE, data_word[7:0]};
      3'd2: tail_word = {8'h00, mme_pkg::PAD_BYTE, data_word[15:0]};
      3'd3: tail_word = {mme_pkg::PAD_BYTE, data_word[23:0]};
      default: tail_word = data_word;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mme_pkg::ST_IDLE;
      key_low   <= '0;
      key_high  <= '0;
      left      <= '0;
      right     <= '0;
      in_frame  <= 1'b0;
      emit      <= 1'b0;
      step      <= '0;
      blk_left  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        if (cfg_index == mme_pkg::REG_KEY_LOW) begin
          key_low <= cfg_wdata;
        end else begin
          key_high <= cfg_wdata;
        end
      end

      if (accept) begin
        step <= '0;
        if (command == mme_pkg::CMD_START) begin
          left     <= key_low;
          right    <= key_high;
          in_frame <= 1'b1;
          emit     <= 1'b0;
          blk_left <= 2'd3;
        end else if (in_frame) begin
          if (!last) begin
            emit     <= 1'b0;
            blk_left <= 2'd0;
          end else begin
            emit     <= 1'b1;
            in_frame <= 1'b0;
            blk_left <= valid_bytes[2] ? 2'd2 : 2'd1;
          end
        end
      end

      if (run_en) begin
        left  <= left_next;
        right <= right_next;
        step  <= step + 2'd1;
        if (step == 2'd3) begin
          blk_left <= blk_left - 2'd1;
        end
      end

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      expected <= expected_mic;
      if (command == mme_pkg::CMD_START) begin
        word_q[0] <= dest_addr[31:0];
        word_q[1] <= {src_addr[15:0], dest_addr[47:32]};
        word_q[2] <= src_addr[47:16];
        word_q[3] <= {24'h000000, priority_req};
      end else if (!last) begin
        word_q[0] <= data_word;
        word_q[1] <= '0;
        word_q[2] <= '0;
        word_q[3] <= '0;
      end else begin
        word_q[0] <= tail_word;
        word_q[1] <= valid_bytes[2] ? mme_pkg::PAD_WORD : '0;
        word_q[2] <= '0;
        word_q[3] <= '0;
      end
    end else if (run_en && step == 2'd3) begin
      // advance to the next block word
      word_q[0] <= word_q[1];
      word_q[1] <= word_q[2];
      word_q[2] <= word_q[3];
      word_q[3] <= '0;
    end

    if (load_out) begin
      mic_left  <= left;
      mic_right <= right;
      mic_match <= ({right, left} == expected);
    end
  end

  a_drop_outside_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && command == mme_pkg::CMD_DATA && !in_frame) |=> (state == mme_pkg::ST_IDLE))
    else $error("data outside a frame started work");

  a_start_opens_frame: assert property (@(posedge clk) disable iff (rst)
    (accept && command == mme_pkg::CMD_START) |=> (state == mme_pkg::ST_RUN && in_frame))
    else $error("start did not open a frame");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == mme_pkg::ST_RUN && run_done) |=> (state != mme_pkg::ST_RUN))
    else $error("sequencer ran past the last block");

  a_emit_closed: assert property (@(posedge clk) disable iff (rst)
    (state == mme_pkg::ST_EMIT) |-> !in_frame)
    else $error("result emitted with frame still open");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == mme_pkg::ST_EMIT))
    else $error("result appeared without an emit step");

endmodule

`default_nettype wire
